// ===== rtl/core/pnop_pkg.sv =====
`default_nettype none

package pnop_pkg;

    // Grid and gradient format.
    localparam int GridBits   = 7;
    localparam int AddrBits   = 2 * GridBits;
    localparam int GradBits   = 16;
    localparam int GradFrac   = GradBits - 2;

    // Octave cell sizes are 32, 16 and 8 pixels, as log2.
    localparam int BaseShift  = 5;
    localparam int NumOctaves = 3;
    localparam int NumCorners = 4;
    localparam int NumReads   = NumOctaves * NumCorners;
    localparam int NumBanks   = NumReads / 2;

    // Value widths along the datapath.
    localparam int FracBits   = 16;
    localparam int DistBits   = FracBits + 2;
    localparam int SumBits    = DistBits + GradBits + 1;
    localparam int DotBits    = 20;
    localparam int OctBits    = 19;
    localparam int TotalBits  = 22;

    // floor(t / 7) = (t * DivSevenMul) >> DivSevenShift for t below 2^22.
    localparam int DivSevenShift = 26;
    localparam logic [23:0] DivSevenMul = 24'd9586981;

    // One stored gradient.
    typedef struct packed {
        logic signed [GradBits-1:0] gy;
        logic signed [GradBits-1:0] gx;
    } gradient_t;

    // Input opcodes.
    localparam logic OpWrite = 1'b0;
    localparam logic OpEval  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/pnop_grad_store.sv =====
`default_nettype none

module pnop_grad_store
    import pnop_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [AddrBits-1:0] wr_addr,
    input  wire gradient_t           wr_data,
    input  wire logic                rd_en,
    input  wire logic [AddrBits-1:0] rd_addr [NumReads],
    output      gradient_t           rd_data [NumReads]
);

    // Each bank holds a full copy of the grid and serves two corner reads.
    for (genvar b = 0; b < NumBanks; b++) begin : g_bank
        gradient_t mem [2**AddrBits];
        gradient_t rd_a_reg;
        gradient_t rd_b_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                rd_a_reg <= mem[rd_addr[2*b]];
                rd_b_reg <= mem[rd_addr[2*b+1]];
            end
        end

        assign rd_data[2*b]   = rd_a_reg;
        assign rd_data[2*b+1] = rd_b_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/core/pnop_octave.sv =====
`default_nettype none

module pnop_octave
    import pnop_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [FracBits-1:0]        fx,
    input  wire logic [FracBits-1:0]        fy,
    input  wire gradient_t                  grad [NumCorners],
    output      logic signed [OctBits-1:0]  oct
);

    localparam logic signed [DistBits-1:0] OneDist = DistBits'(1 << FracBits);
    localparam logic [FracBits+1:0] ThreeOne = (FracBits+2)'(3 << FracBits);

    logic signed [DistBits-1:0] dx [NumCorners];
    logic signed [DistBits-1:0] dy [NumCorners];
    logic signed [SumBits-1:0]  dsum_next [NumCorners];
    logic signed [SumBits-1:0]  dsum_reg  [NumCorners];
    logic [2*FracBits-1:0]      sqx_reg, sqy_reg;
    logic [FracBits-1:0]        fxb_reg, fyb_reg;
    logic [FracBits+1:0]        kx, ky;
    logic [3*FracBits+1:0]      fadex, fadey;
    logic signed [DotBits-1:0]  dot_reg [NumCorners];
    logic [FracBits-1:0]        sx_reg, sy_reg, syd_reg;
    logic signed [DotBits:0]    diff_t, diff_b, diff_v;
    logic signed [DotBits+FracBits+1:0] prod_t, prod_b, prod_v;
    logic signed [DotBits:0]    top_next, bot_next, v_next;
    logic signed [DotBits:0]    top_reg, bot_reg;
    logic signed [DotBits+1:0]  biased;
    logic signed [OctBits-1:0]  oct_reg;

    // Corner distances: the far corner on an axis is one cell away.
    always_comb
    begin
        for (int c = 0; c < NumCorners; c++)
        begin
            dx[c] = signed'({2'b00, fx}) - ((c % 2 == 1) ? OneDist : '0);
            dy[c] = signed'({2'b00, fy}) - ((c / 2 == 1) ? OneDist : '0);
            dsum_next[c] = SumBits'(dx[c] * grad[c].gx) + SumBits'(dy[c] * grad[c].gy);
        end
    end

    // Stage one: dot products and squares of the fractions.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsum_reg <= dsum_next;
            sqx_reg  <= fx * fx;
            sqy_reg  <= fy * fy;
            fxb_reg  <= fx;
            fyb_reg  <= fy;
        end
    end

    // Fade weights w*w*(3 - 2w).
    assign kx    = ThreeOne - {1'b0, fxb_reg, 1'b0};
    assign ky    = ThreeOne - {1'b0, fyb_reg, 1'b0};
    assign fadex = sqx_reg * kx;
    assign fadey = sqy_reg * ky;

    // Stage two: scaled dot products and fade weights.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NumCorners; c++)
            begin
                dot_reg[c] <= DotBits'(dsum_reg[c] >>> GradFrac);
            end
            sx_reg <= fadex[2*FracBits +: FracBits];
            sy_reg <= fadey[2*FracBits +: FracBits];
        end
    end

    // Blend along x for the top and bottom edges.
    always_comb
    begin
        diff_t   = (DotBits+1)'(dot_reg[1]) - (DotBits+1)'(dot_reg[0]);
        diff_b   = (DotBits+1)'(dot_reg[3]) - (DotBits+1)'(dot_reg[2]);
        prod_t   = diff_t * signed'({1'b0, sx_reg});
        prod_b   = diff_b * signed'({1'b0, sx_reg});
        top_next = (DotBits+1)'(dot_reg[0]) + (DotBits+1)'(prod_t >>> FracBits);
        bot_next = (DotBits+1)'(dot_reg[2]) + (DotBits+1)'(prod_b >>> FracBits);
    end

    // Stage three: edge values.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            syd_reg <= sy_reg;
        end
    end

    // Blend along y and map to (v + 1) / 2.
    always_comb
    begin
        diff_v = bot_reg - top_reg;
        prod_v = diff_v * signed'({1'b0, syd_reg});
        v_next = top_reg + (DotBits+1)'(prod_v >>> FracBits);
        biased = (DotBits+2)'(v_next) + (DotBits+2)'(1 << FracBits);
    end

    // Stage four: octave value.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oct_reg <= OctBits'(biased >>> 1);
        end
    end

    assign oct = oct_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pnop_combine.sv =====
`default_nettype none

module pnop_combine
    import pnop_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic signed [OctBits-1:0] oct [NumOctaves],
    output      logic [15:0]               noise_fraction,
    output      logic [7:0]                noise_byte
);

    logic signed [TotalBits-1:0] total_reg;
    logic [TotalBits-2:0]        tpos;
    logic [TotalBits+23:0]       qf_prod;
    logic [TotalBits+7:0]        scaled;
    logic                        neg_reg;
    logic [TotalBits-3:0]        qf_reg;
    logic [12:0]                 pb_reg;
    logic [36:0]                 qb_prod;
    logic [12:0]                 qb;
    logic [15:0]                 frac_reg;
    logic [7:0]                  byte_reg;

    // Stage one: weighted sum 4*o0 + 2*o1 + o2.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            total_reg <= (TotalBits'(oct[0]) <<< 2) + (TotalBits'(oct[1]) <<< 1)
                         + TotalBits'(oct[2]);
        end
    end

    // Divide by seven through a reciprocal; the byte path scales by 255 first.
    assign tpos    = total_reg[TotalBits-2:0];
    assign qf_prod = tpos * DivSevenMul;
    assign scaled  = tpos * 9'd255;

    // Stage two: quotient of the fraction and the scaled byte numerator.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= total_reg[TotalBits-1];
            qf_reg  <= (TotalBits-2)'(qf_prod >> DivSevenShift);
            pb_reg  <= scaled[FracBits +: 13];
        end
    end

    assign qb_prod = pb_reg * DivSevenMul;
    assign qb      = 13'(qb_prod >> DivSevenShift);

    // Stage three: saturate into the output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg)
            begin
                frac_reg <= '0;
                byte_reg <= '0;
            end
            else
            begin
                frac_reg <= (qf_reg > 20'd65535) ? 16'hFFFF : qf_reg[15:0];
                byte_reg <= (qb > 13'd255) ? 8'hFF : qb[7:0];
            end
        end
    end

    assign noise_fraction = frac_reg;
    assign noise_byte     = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/core/perlin_noise_octave_pixel_core.sv =====
// Three-octave gradient noise over a 128 x 128 grid of stored gradients.
// Input channel s_axis: tuser is the opcode. Opcode write stores grad_x and
// grad_y at grid cell (cell_x, cell_y) and gives no result. Opcode eval
// computes noise at (pixel_x, pixel_y) with cells of 32, 16 and 8 pixels.
// Output channel m_axis carries one transfer per eval item, in order:
// noise in Q0.16 and its grey level, both saturated.
// Throughput is one item per cycle unless the receiver stalls; twelve
// corner gradients are read each cycle from six copies of the grid, each
// copy with two read ports, and every write goes to all copies. A write
// is seen by an eval accepted in the very next cycle. A result passes
// the lookup registers, octave stages and combine stages to the output
// register. The pipeline moves as a whole: when the receiver stalls with
// a result waiting, s_axis_tready drops and every stage holds.
// Reset clears the stage valid bits only; the grid contents are undefined
// until written, and every gradient used must be written first.
`default_nettype none

module perlin_noise_octave_pixel_core
    import pnop_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [26:20] cell_x, [33:27] cell_y,
    // [49:34] grad_x, [65:50] grad_y, [71:66] zero
    input  wire logic [71:0] s_axis_tdata,
    // [0] opcode
    input  wire logic [0:0]  s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] noise_fraction, [23:16] noise_byte
    output      logic [23:0] m_axis_tdata
);

    localparam int Depth = 8;

    logic [9:0]          pixel_x, pixel_y;
    logic [GridBits-1:0] cell_x, cell_y;
    gradient_t           wr_grad;
    logic                en, accept, wr_en, eval_in;
    logic [Depth-1:0]    vld_reg, vld_next;
    logic [AddrBits-1:0] rd_addr [NumReads];
    gradient_t           rd_data [NumReads];
    logic [FracBits-1:0] fx_next [NumOctaves];
    logic [FracBits-1:0] fy_next [NumOctaves];
    logic [FracBits-1:0] fx_reg [NumOctaves];
    logic [FracBits-1:0] fy_reg [NumOctaves];
    logic [GridBits-1:0] ix [NumOctaves];
    logic [GridBits-1:0] iy [NumOctaves];
    logic signed [OctBits-1:0] oct [NumOctaves];
    logic [15:0]         noise_fraction;
    logic [7:0]          noise_byte;

    assign pixel_x    = s_axis_tdata[9:0];
    assign pixel_y    = s_axis_tdata[19:10];
    assign cell_x     = s_axis_tdata[26:20];
    assign cell_y     = s_axis_tdata[33:27];
    assign wr_grad.gx = s_axis_tdata[49:34];
    assign wr_grad.gy = s_axis_tdata[65:50];

    // The whole pipeline advances unless a result waits on a stalled receiver.
    assign en            = !vld_reg[Depth-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign wr_en         = accept && (s_axis_tuser[0] == OpWrite);
    assign eval_in       = accept && (s_axis_tuser[0] == OpEval);

    // Cell indices, fractions and corner addresses of each octave.
    always_comb
    begin
        for (int k = 0; k < NumOctaves; k++)
        begin
            ix[k] = GridBits'(pixel_x >> (BaseShift - k));
            iy[k] = GridBits'(pixel_y >> (BaseShift - k));
            fx_next[k] = FracBits'(pixel_x << (FracBits - BaseShift + k));
            fy_next[k] = FracBits'(pixel_y << (FracBits - BaseShift + k));
            for (int c = 0; c < NumCorners; c++)
            begin
                rd_addr[k*NumCorners+c] = {ix[k] + GridBits'(c % 2),
                                           iy[k] + GridBits'(c / 2)};
            end
        end
    end

    // Gradient lookups, registered alongside the fractions.
    pnop_grad_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr ({cell_x, cell_y}),
        .wr_data (wr_grad),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fx_reg <= fx_next;
            fy_reg <= fy_next;
        end
    end

    // One evaluation pipeline per octave.
    for (genvar k = 0; k < NumOctaves; k++) begin : g_oct
        pnop_octave u_octave (
            .clk  (clk),
            .en   (en),
            .fx   (fx_reg[k]),
            .fy   (fy_reg[k]),
            .grad (rd_data[k*NumCorners +: NumCorners]),
            .oct  (oct[k])
        );
    end

    pnop_combine u_combine (
        .clk            (clk),
        .en             (en),
        .oct            (oct),
        .noise_fraction (noise_fraction),
        .noise_byte     (noise_byte)
    );

    // Valid bits travel with the data through every stage.
    assign vld_next = {vld_reg[Depth-2:0], eval_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign m_axis_tvalid = vld_reg[Depth-1];
    assign m_axis_tdata  = {noise_byte, noise_fraction};

endmodule

`default_nettype wire
